// File: hw/rtl/cts_edit_pkg.sv
// ----------------------------------------------------------------------------
// cts_edit_pkg
// Shared codes, limits and helper functions for the calendar set-mode editor.
// ----------------------------------------------------------------------------
package cts_edit_pkg;

    // Request opcodes (carried on s_tuser)
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_MODE = 3'd1;
    localparam logic [2:0] OP_NEXT = 3'd2;
    localparam logic [2:0] OP_INC  = 3'd3;
    localparam logic [2:0] OP_DEC  = 3'd4;

    // Field selector codes
    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;
    localparam logic [2:0] FLD_LAST   = FLD_SECOND;

    // Field limits, all held at the width of the widest field
    localparam logic [6:0] YEAR_MAX  = 7'd99;
    localparam logic [6:0] MONTH_MAX = 7'd12;
    localparam logic [6:0] HOUR_MAX  = 7'd23;
    localparam logic [6:0] MS_MAX    = 7'd59;
    localparam logic [6:0] LO_ZERO   = 7'd0;
    localparam logic [6:0] LO_ONE    = 7'd1;

    // Days in month; leap February when year is a multiple of four.
    // Any month code outside the calendar counts as 31 days.
    function automatic logic [4:0] month_len(input logic [3:0] month,
                                             input logic [6:0] year);
        logic [4:0] len;
        case (month)
            4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Wrapping step: out-of-range values go to lo when stepping up and to hi when stepping down.
    function automatic logic [6:0] step_val(input logic       up,
                                            input logic [6:0] v,
                                            input logic [6:0] lo,
                                            input logic [6:0] hi);
        logic [6:0] r;
        if (up) begin
            r = (v >= hi || v < lo) ? lo : v + 7'd1;
        end else begin
            r = (v <= lo || v > hi) ? hi : v - 7'd1;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/calendar_time_set_editor.sv
// ----------------------------------------------------------------------------
// calendar_time_set_editor
// Set-mode editor for a real-time clock calendar (year .. second).
// A request passes from the input register to the result register. Throughput:
// one request per cycle while the result side takes results; a stall on
// m_tready holds both stages.
// Reset (aresetn low, synchronous): both stages empty, show mode, field 0,
// date 00-01-01 and time 00:00:00.
// ----------------------------------------------------------------------------
module calendar_time_set_editor (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] load_year, [10:7] load_month, [15:11] load_day, [20:16] load_hour,
    // [26:21] load_minute, [32:27] load_second, [39:33] zero
    input  logic [39:0] s_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_tuser,
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] setting_mode, [3:1] selected_field, [10:4] year_out,
    // [14:11] month_out, [19:15] day_out, [24:20] hour_out,
    // [30:25] minute_out, [36:31] second_out, [37] commit, [39:38] zero
    output logic [39:0] m_tdata
);

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic       in_valid_reg, in_valid_next;
    logic [2:0] in_op_reg;
    logic [6:0] in_year_reg;
    logic [3:0] in_month_reg;
    logic [4:0] in_day_reg;
    logic [4:0] in_hour_reg;
    logic [5:0] in_minute_reg;
    logic [5:0] in_second_reg;

    // Result register stage
    logic       out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg, out_data_next;

    // Editor state
    logic       mode_reg,   mode_next;
    logic [2:0] field_reg,  field_next;
    logic [6:0] year_reg,   year_next;
    logic [3:0] month_reg,  month_next;
    logic [4:0] day_reg,    day_next;
    logic [4:0] hour_reg,   hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic       commit;

    logic s_accept;
    logic advance;   // request moves from input stage into result stage

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // Request decode and state update
    // ------------------------------------------------------------------
    always_comb begin
        logic [6:0] cur_val;
        logic [6:0] lo;
        logic [6:0] hi;
        logic [6:0] new_val;

        mode_next   = mode_reg;
        field_next  = field_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        commit      = 1'b0;

        // selected field, widened to seven bits, with its bounds
        case (field_reg)
            cts_edit_pkg::FLD_YEAR: begin
                cur_val = year_reg;
                lo      = cts_edit_pkg::LO_ZERO;
                hi      = cts_edit_pkg::YEAR_MAX;
            end
            cts_edit_pkg::FLD_MONTH: begin
                cur_val = {3'b000, month_reg};
                lo      = cts_edit_pkg::LO_ONE;
                hi      = cts_edit_pkg::MONTH_MAX;
            end
            cts_edit_pkg::FLD_DAY: begin
                cur_val = {2'b00, day_reg};
                lo      = cts_edit_pkg::LO_ONE;
                hi      = {2'b00, cts_edit_pkg::month_len(month_reg, year_reg)};
            end
            cts_edit_pkg::FLD_HOUR: begin
                cur_val = {2'b00, hour_reg};
                lo      = cts_edit_pkg::LO_ZERO;
                hi      = cts_edit_pkg::HOUR_MAX;
            end
            cts_edit_pkg::FLD_MINUTE: begin
                cur_val = {1'b0, minute_reg};
                lo      = cts_edit_pkg::LO_ZERO;
                hi      = cts_edit_pkg::MS_MAX;
            end
            default: begin
                cur_val = {1'b0, second_reg};
                lo      = cts_edit_pkg::LO_ZERO;
                hi      = cts_edit_pkg::MS_MAX;
            end
        endcase

        new_val = cts_edit_pkg::step_val(in_op_reg == cts_edit_pkg::OP_INC,
                                         cur_val, lo, hi);

        case (in_op_reg)
            cts_edit_pkg::OP_LOAD: begin
                if (!mode_reg) begin
                    year_next   = in_year_reg;
                    month_next  = in_month_reg;
                    day_next    = in_day_reg;
                    hour_next   = in_hour_reg;
                    minute_next = in_minute_reg;
                    second_next = in_second_reg;
                end
            end
            cts_edit_pkg::OP_MODE: begin
                if (!mode_reg) begin
                    mode_next  = 1'b1;
                    field_next = cts_edit_pkg::FLD_YEAR;
                end else begin
                    mode_next = 1'b0;
                    commit    = 1'b1;
                end
            end
            cts_edit_pkg::OP_NEXT: begin
                if (mode_reg) begin
                    field_next = (field_reg >= cts_edit_pkg::FLD_LAST)
                               ? cts_edit_pkg::FLD_YEAR : field_reg + 3'd1;
                end
            end
            cts_edit_pkg::OP_INC,
            cts_edit_pkg::OP_DEC: begin
                if (mode_reg) begin
                    case (field_reg)
                        cts_edit_pkg::FLD_YEAR:   year_next   = new_val;
                        cts_edit_pkg::FLD_MONTH:  month_next  = new_val[3:0];
                        cts_edit_pkg::FLD_DAY:    day_next    = new_val[4:0];
                        cts_edit_pkg::FLD_HOUR:   hour_next   = new_val[4:0];
                        cts_edit_pkg::FLD_MINUTE: minute_next = new_val[5:0];
                        default:                  second_next = new_val[5:0];
                    endcase
                    // day recheck against the month as it now stands
                    if (day_next == 5'd0 ||
                        day_next > cts_edit_pkg::month_len(month_next, year_next)) begin
                        day_next = 5'd1;
                    end
                end
            end
            default: begin
                // unused opcodes leave the state alone
            end
        endcase

        out_data_next = {2'b00, commit, second_next, minute_next, hour_next,
                         day_next, month_next, year_next, field_next, mode_next};
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            field_reg     <= cts_edit_pkg::FLD_YEAR;
            year_reg      <= 7'd0;
            month_reg     <= 4'd1;
            day_reg       <= 5'd1;
            hour_reg      <= 5'd0;
            minute_reg    <= 6'd0;
            second_reg    <= 6'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                mode_reg   <= mode_next;
                field_reg  <= field_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg     <= s_tuser;
            in_year_reg   <= s_tdata[6:0];
            in_month_reg  <= s_tdata[10:7];
            in_day_reg    <= s_tdata[15:11];
            in_hour_reg   <= s_tdata[20:16];
            in_minute_reg <= s_tdata[26:21];
            in_second_reg <= s_tdata[32:27];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        field_reg <= cts_edit_pkg::FLD_LAST)
        else $error("selected field out of range");

    a_mode_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == cts_edit_pkg::OP_MODE) |=>
            (mode_reg != $past(mode_reg)))
        else $error("mode key did not toggle set mode");

    a_commit_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[37]) |-> (!out_data_reg[0] && !mode_reg))
        else $error("commit raised while still in set mode");

    a_show_no_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !mode_reg && in_op_reg != cts_edit_pkg::OP_LOAD) |=>
            ($stable(year_reg) && $stable(month_reg) && $stable(day_reg) &&
             $stable(hour_reg) && $stable(minute_reg) && $stable(second_reg)))
        else $error("time changed in show mode without a load");

endmodule

// File: sim/cts_edit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cts_edit_checker
// Watches both channels of the calendar set-mode editor. It keeps its own copy
// of the editor state, works out the clock view each accepted request should
// produce, and compares every returned view field by field in order.
// ----------------------------------------------------------------------------
module cts_edit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          views_owed,
    output int          views_checked,
    output int          commits_seen
);

    // Result word, lowest field last
    typedef struct packed {
        logic [1:0] pad;
        logic       commit;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic [2:0] field;
        logic       mode;
    } clock_view_t;

    clock_view_t pending_views[$];

    // Shadow copy of the editor state
    logic       set_mode;
    logic [2:0] cur_field;
    logic [6:0] year_q;
    logic [3:0] month_q;
    logic [4:0] day_q;
    logic [4:0] hour_q;
    logic [5:0] minute_q;
    logic [5:0] second_q;

    function automatic int days_in(input logic [3:0] mon, input logic [6:0] yr);
        case (mon)
            4'd2:                      return (yr % 4 == 0) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 30;
            default:                   return 31;
        endcase
    endfunction

    // Increment or decrement the selected field, then recheck the day
    task automatic nudge_field(input logic up);
        int v;
        int lo;
        int hi;
        lo = 0;
        case (cur_field)
            cts_edit_pkg::FLD_YEAR: begin
                v = year_q; hi = cts_edit_pkg::YEAR_MAX;
            end
            cts_edit_pkg::FLD_MONTH: begin
                v = month_q; lo = 1; hi = cts_edit_pkg::MONTH_MAX;
            end
            cts_edit_pkg::FLD_DAY: begin
                v = day_q; lo = 1; hi = days_in(month_q, year_q);
            end
            cts_edit_pkg::FLD_HOUR: begin
                v = hour_q; hi = cts_edit_pkg::HOUR_MAX;
            end
            cts_edit_pkg::FLD_MINUTE: begin
                v = minute_q; hi = cts_edit_pkg::MS_MAX;
            end
            default: begin
                v = second_q; hi = cts_edit_pkg::MS_MAX;
            end
        endcase
        if (up)
            v = (v >= hi || v < lo) ? lo : v + 1;
        else
            v = (v <= lo || v > hi) ? hi : v - 1;
        case (cur_field)
            cts_edit_pkg::FLD_YEAR:   year_q   = 7'(v);
            cts_edit_pkg::FLD_MONTH:  month_q  = 4'(v);
            cts_edit_pkg::FLD_DAY:    day_q    = 5'(v);
            cts_edit_pkg::FLD_HOUR:   hour_q   = 5'(v);
            cts_edit_pkg::FLD_MINUTE: minute_q = 6'(v);
            default:                  second_q = 6'(v);
        endcase
        if (day_q == 0 || day_q > days_in(month_q, year_q))
            day_q = 5'd1;
    endtask

    task automatic apply_request(input logic [2:0] op, input logic [39:0] word,
                                 output clock_view_t view);
        logic commit;
        commit = 1'b0;
        case (op)
            cts_edit_pkg::OP_LOAD: begin
                // loads only land in show mode, stored as given
                if (!set_mode) begin
                    year_q   = word[6:0];
                    month_q  = word[10:7];
                    day_q    = word[15:11];
                    hour_q   = word[20:16];
                    minute_q = word[26:21];
                    second_q = word[32:27];
                end
            end
            cts_edit_pkg::OP_MODE: begin
                if (!set_mode) begin
                    set_mode  = 1'b1;
                    cur_field = cts_edit_pkg::FLD_YEAR;
                end else begin
                    set_mode = 1'b0;
                    commit   = 1'b1;
                end
            end
            cts_edit_pkg::OP_NEXT: begin
                if (set_mode)
                    cur_field = (cur_field >= cts_edit_pkg::FLD_LAST)
                              ? cts_edit_pkg::FLD_YEAR : cur_field + 3'd1;
            end
            cts_edit_pkg::OP_INC, cts_edit_pkg::OP_DEC: begin
                if (set_mode)
                    nudge_field(op == cts_edit_pkg::OP_INC);
            end
            default: ;
        endcase
        view = '{pad: 2'b00, commit: commit, second: second_q, minute: minute_q,
                 hour: hour_q, day: day_q, month: month_q, year: year_q,
                 field: cur_field, mode: set_mode};
    endtask

    function automatic string show_view(input clock_view_t v);
        return $sformatf("mode=%0d sel=%0d %0d-%0d-%0d %0d:%0d:%0d commit=%0d",
                         v.mode, v.field, v.year, v.month, v.day,
                         v.hour, v.minute, v.second, v.commit);
    endfunction

    function automatic string wrong_fields(input clock_view_t w, input clock_view_t g);
        string s;
        s = "";
        if (g.mode   !== w.mode)   s = {s, " setting_mode"};
        if (g.field  !== w.field)  s = {s, " selected_field"};
        if (g.year   !== w.year)   s = {s, " year"};
        if (g.month  !== w.month)  s = {s, " month"};
        if (g.day    !== w.day)    s = {s, " day"};
        if (g.hour   !== w.hour)   s = {s, " hour"};
        if (g.minute !== w.minute) s = {s, " minute"};
        if (g.second !== w.second) s = {s, " second"};
        if (g.commit !== w.commit) s = {s, " commit"};
        return s;
    endfunction

    always @(posedge aclk) begin : watch
        clock_view_t got;
        clock_view_t want;
        clock_view_t fresh;
        string       bad;
        if (!aresetn) begin
            set_mode      = 1'b0;
            cur_field     = cts_edit_pkg::FLD_YEAR;
            year_q        = '0;
            month_q       = 4'd1;
            day_q         = 5'd1;
            hour_q        = '0;
            minute_q      = '0;
            second_q      = '0;
            fail_count    = 0;
            views_checked = 0;
            commits_seen  = 0;
            pending_views.delete();
        end else begin
            // results first: a request cannot come back in the cycle it enters
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_views.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unrequested result: %s", $time, show_view(got));
                end else begin
                    want = pending_views.pop_front();
                    views_checked++;
                    if (want.commit) commits_seen++;
                    bad = wrong_fields(want, got);
                    if (bad != "") begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] result %0d wrong in%s\n  expected %s\n  actual   %s",
                                     $time, views_checked, bad, show_view(want),
                                     show_view(got));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata, fresh);
                pending_views.push_back(fresh);
            end
        end
        views_owed = pending_views.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the calendar set-mode editor. A directed opening walks
// the field wraps, leap and short-month day rechecks, ignored requests and
// out-of-range loads; random edit sessions with noise follow. Both sides idle
// at random and the result side holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_ITEMS     = 1100;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;    // two-stage pipe, plus margin

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // year, month, day, hour, minute, second from bit 0
    logic [2:0]  s_tuser  = cts_edit_pkg::OP_LOAD;  // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // mode, field, year .. second, commit from bit 0

    int fail_count;
    int views_owed;
    int views_checked;
    int commits_seen;

    int n_sent     = 0;
    int n_sessions = 0;
    int n_holds    = 0;
    bit idle_on    = 1'b1;   // sender gaps enabled for the current stretch
    bit hold_req   = 1'b0;   // asks the receiver for one long hold-off

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    calendar_time_set_editor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cts_edit_checker edit_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .views_owed    (views_owed),
        .views_checked (views_checked),
        .commits_seen  (commits_seen)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Request payload; arguments are cut to field width, spare top bits zero
    function automatic logic [39:0] load_word(input int yr, input int mon,
                                              input int dy, input int hr,
                                              input int mi, input int sec);
        return {7'd0, 6'(sec), 6'(mi), 5'(hr), 5'(dy), 4'(mon), 7'(yr)};
    endfunction

    function automatic logic [39:0] noise_word();
        return load_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Clock chip values, now and then anything the field widths allow
    function automatic logic [39:0] chip_word();
        if ($urandom_range(0, 4) == 0)
            return noise_word();
        return load_word($urandom_range(0, 99), $urandom_range(1, 12),
                         $urandom_range(1, 31), $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    // Offer one request and hold it until the editor takes it
    task automatic send(input logic [2:0] op, input logic [39:0] word);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // Receiver: random back-pressure, long ready runs, and the requested hold-offs
    initial begin : receiver
        int cnt;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n_holds++;
                m_tready <= 1'b0;
                cnt = 0;
                while (cnt < HOLD_CYCLES) begin
                    @(posedge aclk);
                    cnt++;
                end
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(50, 200)) @(posedge aclk);
                else
                    repeat ($urandom_range(1, 12)) @(posedge aclk);
                cnt = pick_gap();
                if (cnt > 0) begin
                    m_tready <= 1'b0;
                    repeat (cnt) @(posedge aclk);
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still owed", cycles, views_owed);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int r;
        logic [2:0] op;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening
        send(cts_edit_pkg::OP_INC, noise_word());           // edit in show mode: ignored
        send(cts_edit_pkg::OP_LOAD, load_word(0, 2, 29, 23, 59, 59));  // leap February 29th
        send(cts_edit_pkg::OP_MODE, noise_word());
        send(cts_edit_pkg::OP_DEC, noise_word());           // year 0 wraps to 99, day 29 -> 1
        // load in set mode: ignored
        send(cts_edit_pkg::OP_LOAD, load_word(127, 15, 31, 31, 63, 63));
        send(cts_edit_pkg::OP_NEXT, noise_word());
        send(cts_edit_pkg::OP_INC, noise_word());           // month 2 -> 3
        send(cts_edit_pkg::OP_NEXT, noise_word());
        send(cts_edit_pkg::OP_DEC, noise_word());           // day 1 -> 31
        send(cts_edit_pkg::OP_NEXT, noise_word());
        send(cts_edit_pkg::OP_INC, noise_word());           // hour 23 -> 0
        send(cts_edit_pkg::OP_NEXT, noise_word());
        send(cts_edit_pkg::OP_INC, noise_word());           // minute 59 -> 0
        send(cts_edit_pkg::OP_NEXT, noise_word());
        send(cts_edit_pkg::OP_DEC, noise_word());           // second 59 -> 58
        send(cts_edit_pkg::OP_NEXT, noise_word());          // selection wraps to year
        send(cts_edit_pkg::OP_NEXT, noise_word());
        send(cts_edit_pkg::OP_INC, noise_word());           // April: day 31 -> 1
        send(cts_edit_pkg::OP_MODE, noise_word());          // commit
        send(3'd5, noise_word());                           // unused opcodes
        send(3'd7, noise_word());
        // out-of-range load kept
        send(cts_edit_pkg::OP_LOAD, load_word(127, 15, 0, 31, 63, 63));
        send(cts_edit_pkg::OP_MODE, noise_word());
        send(cts_edit_pkg::OP_INC, noise_word());           // year above max -> 0, day 0 -> 1
        send(cts_edit_pkg::OP_MODE, noise_word());

        // Random edit sessions: load, enter, edits, leave; some noise between
        while (n_sent < N_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 70)
                send(cts_edit_pkg::OP_LOAD, chip_word());
            if ($urandom_range(0, 99) < 15) begin
                // noise that keeps the mode parity: no mode key here
                repeat ($urandom_range(1, 4)) begin
                    r  = $urandom_range(0, 6);
                    op = (r == 0) ? cts_edit_pkg::OP_LOAD : 3'(r + 1);
                    send(op, noise_word());
                end
            end
            send(cts_edit_pkg::OP_MODE, noise_word());
            repeat ($urandom_range(3, 30)) begin
                r = $urandom_range(0, 99);
                if (r < 30)      op = cts_edit_pkg::OP_NEXT;
                else if (r < 62) op = cts_edit_pkg::OP_INC;
                else if (r < 94) op = cts_edit_pkg::OP_DEC;
                else if (r < 97) op = cts_edit_pkg::OP_LOAD;
                else             op = 3'($urandom_range(5, 7));
                send(op, (op == cts_edit_pkg::OP_LOAD) ? chip_word() : noise_word());
            end
            send(cts_edit_pkg::OP_MODE, noise_word());
            n_sessions++;
            if (n_sessions == 8 || n_sessions == 45)
                hold_req = 1'b1;
        end
        s_tvalid <= 1'b0;

        // Drain, then let the pipe settle
        @(posedge aclk);
        wait (views_owed == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d requests in %0d edit sessions, %0d long receiver hold-offs",
                 n_sent, n_sessions, n_holds);
        $display("Checked %0d results, %0d of them commits, %0d mismatches",
                 views_checked, commits_seen, fail_count);
        if (fail_count == 0 && views_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
